[sv/tgr_pkg.sv]
// Shared types, codes and helpers for the touch gesture recogniser.
package tgr_pkg;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [2:0] KIND_TAP       = 3'd0;
    localparam logic [2:0] KIND_DOUBLE    = 3'd1;
    localparam logic [2:0] KIND_PAN_BEGAN = 3'd2;
    localparam logic [2:0] KIND_PAN       = 3'd3;
    localparam logic [2:0] KIND_PAN_ENDED = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;

    localparam logic [2:0] REG_PIXEL_SCALE   = 3'd0;
    localparam logic [2:0] REG_RELEASE_DELAY = 3'd1;
    localparam logic [2:0] REG_TAP_MIN       = 3'd2;
    localparam logic [2:0] REG_TAP_MAX       = 3'd3;
    localparam logic [2:0] REG_PAN_MIN       = 3'd4;
    localparam logic [2:0] REG_PAN_TRAVEL    = 3'd5;
    localparam logic [2:0] REG_DT_RADIUS     = 3'd6;
    localparam logic [2:0] REG_DT_WINDOW     = 3'd7;

    localparam int          MAX_RESULTS = 8;
    localparam logic [13:0] PIX_MAX     = 14'h3FFF;
    localparam logic [15:0] TRAVEL_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] touch_id;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] prev_x;
        logic [11:0] prev_y;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_id;
        logic [13:0] out_x;
        logic [13:0] out_y;
        logic [15:0] out_travel;
        logic        panning_now;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [2:0]  pixel_scale;
        logic [15:0] release_delay_ms;
        logic [15:0] tap_min_ms;
        logic [15:0] tap_max_ms;
        logic [15:0] pan_min_ms;
        logic [15:0] pan_min_travel;
        logic [12:0] double_tap_radius;
        logic [15:0] double_tap_window_ms;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic scan;
        logic act;
        logic sqrt_step;
        logic move_write;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       scan_last;
        logic       match;
        logic       sqrt_last;
        logic       n_zero;
        logic       emit_last;
    } ctrl_sts_t;

    function automatic logic [13:0] to_pixels(input logic [11:0] p, input logic [2:0] s);
        logic [14:0] v;
        v = {3'b000, p} * {12'b0, s};
        return (v > {1'b0, PIX_MAX}) ? PIX_MAX : v[13:0];
    endfunction

    function automatic logic [28:0] dist_sq(input logic [13:0] ax, input logic [13:0] ay,
                                            input logic [13:0] bx, input logic [13:0] by);
        logic [13:0] dx;
        logic [13:0] dy;
        logic [27:0] sx;
        logic [27:0] sy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        sx = {14'b0, dx} * {14'b0, dx};
        sy = {14'b0, dy} * {14'b0, dy};
        return {1'b0, sx} + {1'b0, sy};
    endfunction

endpackage

[sv/tgr_cfg.sv]
// Configuration register file on the APB-style port.
module tgr_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tgr_pkg::cfg_t       cfg
);

    tgr_pkg::cfg_t cfg_reg;
    tgr_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                tgr_pkg::REG_PIXEL_SCALE:   cfg_next.pixel_scale          = pwdata[2:0];
                tgr_pkg::REG_RELEASE_DELAY: cfg_next.release_delay_ms     = pwdata[15:0];
                tgr_pkg::REG_TAP_MIN:       cfg_next.tap_min_ms           = pwdata[15:0];
                tgr_pkg::REG_TAP_MAX:       cfg_next.tap_max_ms           = pwdata[15:0];
                tgr_pkg::REG_PAN_MIN:       cfg_next.pan_min_ms           = pwdata[15:0];
                tgr_pkg::REG_PAN_TRAVEL:    cfg_next.pan_min_travel       = pwdata[15:0];
                tgr_pkg::REG_DT_RADIUS:     cfg_next.double_tap_radius    = pwdata[12:0];
                tgr_pkg::REG_DT_WINDOW:     cfg_next.double_tap_window_ms = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            tgr_pkg::REG_PIXEL_SCALE:   prdata = {29'b0, cfg_reg.pixel_scale};
            tgr_pkg::REG_RELEASE_DELAY: prdata = {16'b0, cfg_reg.release_delay_ms};
            tgr_pkg::REG_TAP_MIN:       prdata = {16'b0, cfg_reg.tap_min_ms};
            tgr_pkg::REG_TAP_MAX:       prdata = {16'b0, cfg_reg.tap_max_ms};
            tgr_pkg::REG_PAN_MIN:       prdata = {16'b0, cfg_reg.pan_min_ms};
            tgr_pkg::REG_PAN_TRAVEL:    prdata = {16'b0, cfg_reg.pan_min_travel};
            tgr_pkg::REG_DT_RADIUS:     prdata = {19'b0, cfg_reg.double_tap_radius};
            tgr_pkg::REG_DT_WINDOW:     prdata = {16'b0, cfg_reg.double_tap_window_ms};
            default:                    prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_scale          <= 3'd1;
            cfg_reg.release_delay_ms     <= 16'd250;
            cfg_reg.tap_min_ms           <= 16'd150;
            cfg_reg.tap_max_ms           <= 16'd500;
            cfg_reg.pan_min_ms           <= 16'd250;
            cfg_reg.pan_min_travel       <= 16'd10;
            cfg_reg.double_tap_radius    <= 13'd30;
            cfg_reg.double_tap_window_ms <= 16'd300;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/tgr_ctrl.sv]
// Sequencing state machine for the gesture recogniser.
module tgr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tgr_pkg::ctrl_sts_t    sts,
    output tgr_pkg::ctrl_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ACT   = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_MOVEW = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                cmd.act = 1'b1;
                if (sts.command == tgr_pkg::CMD_MOVE && sts.match)
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                begin
                    state_next = S_MOVEW;
                end
            end
            S_MOVEW:
            begin
                cmd.move_write = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.n_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.load)
        else $error("load did not follow accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVEW) |-> $past(state_reg == S_SQRT))
        else $error("move write without root");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.act, cmd.sqrt_step, cmd.move_write, cmd.emit}))
        else $error("several datapath commands at once");

endmodule

[sv/tgr_dp.sv]
// Contact table, scan logic, square root unit and result buffer.
module tgr_dp
#(
    parameter int N = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tgr_pkg::in_t          request,
    input  tgr_pkg::cfg_t         cfg,
    input  tgr_pkg::ctrl_cmd_t    cmd,
    output tgr_pkg::ctrl_sts_t    sts,
    output logic                  result_valid,
    output tgr_pkg::out_t         result
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int RW = $clog2(tgr_pkg::MAX_RESULTS);

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic [13:0] x;
        logic [13:0] y;
        logic [15:0] tr;
    } res_t;

    tgr_pkg::in_t  in_reg;
    logic [13:0]   px_reg, py_reg, qx_reg, qy_reg;
    logic [25:0]   rsq_reg;
    logic [31:0]   now_reg;
    logic          panning_reg;

    logic          valid_reg   [N];
    logic [15:0]   ident_reg   [N];
    logic [13:0]   ex_reg      [N];
    logic [13:0]   ey_reg      [N];
    logic [31:0]   birth_reg   [N];
    logic [31:0]   rtime_reg   [N];
    logic          rel_reg     [N];
    logic [15:0]   travel_reg  [N];
    logic          pan_reg     [N];
    logic          dbl_reg     [N];

    logic [IW-1:0] idx_reg;
    logic          best_found_reg, match_found_reg, free_found_reg;
    logic [IW-1:0] best_idx_reg, match_idx_reg, free_idx_reg;
    logic [28:0]   bestd_reg;

    logic [29:0]   rem_reg;
    logic [29:0]   root_reg;
    logic [29:0]   bit_reg;

    res_t          buf_reg [tgr_pkg::MAX_RESULTS];
    logic [RW:0]   n_reg;
    logic [RW-1:0] k_reg;

    logic          out_valid_reg;
    tgr_pkg::out_t out_reg;

    logic [28:0]   scan_d;
    logic [31:0]   dur;
    logic [31:0]   since;
    logic          tick_push;
    logic [2:0]    tick_kind;
    logic [28:0]   move_d;
    logic [29:0]   trial;
    logic [16:0]   tsum;
    logic          dbl_hit;

    assign scan_d = tgr_pkg::dist_sq(ex_reg[idx_reg], ey_reg[idx_reg], px_reg, py_reg);
    assign dur    = now_reg - birth_reg[idx_reg];
    assign since  = now_reg - rtime_reg[idx_reg];
    assign move_d = tgr_pkg::dist_sq(px_reg, py_reg, qx_reg, qy_reg);
    assign trial  = root_reg + bit_reg;
    assign tsum   = {1'b0, travel_reg[match_idx_reg]} + {2'b0, root_reg[14:0]};
    assign dbl_hit = best_found_reg && ({3'b0, rsq_reg} > bestd_reg)
                     && rel_reg[best_idx_reg] && !pan_reg[best_idx_reg]
                     && ((now_reg - rtime_reg[best_idx_reg])
                         < {16'b0, cfg.double_tap_window_ms});

    always_comb
    begin
        tick_push = 1'b0;
        tick_kind = tgr_pkg::KIND_TAP;
        if (valid_reg[idx_reg])
        begin
            if (rel_reg[idx_reg] && since > {16'b0, cfg.release_delay_ms})
            begin
                if (dbl_reg[idx_reg])
                begin
                    tick_push = 1'b1;
                    tick_kind = tgr_pkg::KIND_DOUBLE;
                end
                else if (pan_reg[idx_reg])
                begin
                    tick_push = 1'b1;
                    tick_kind = tgr_pkg::KIND_PAN_ENDED;
                end
                else if (dur > {16'b0, cfg.tap_min_ms} && dur < {16'b0, cfg.tap_max_ms})
                begin
                    tick_push = 1'b1;
                    tick_kind = tgr_pkg::KIND_TAP;
                end
            end
            else if (dur > {16'b0, cfg.pan_min_ms}
                     && travel_reg[idx_reg] > cfg.pan_min_travel)
            begin
                tick_push = 1'b1;
                tick_kind = pan_reg[idx_reg] ? tgr_pkg::KIND_PAN : tgr_pkg::KIND_PAN_BEGAN;
            end
        end
    end

    assign sts.command   = in_reg.command;
    assign sts.scan_last = (idx_reg == IW'(N - 1));
    assign sts.match     = match_found_reg;
    assign sts.sqrt_last = bit_reg[0];
    assign sts.n_zero    = (n_reg == '0);
    assign sts.emit_last = ({1'b0, k_reg} == n_reg - 1'b1);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            panning_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            out_valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                n_reg <= '0;
                k_reg <= '0;
                if (in_reg.command == tgr_pkg::CMD_TICK)
                begin
                    now_reg <= now_reg + 32'd1;
                end
            end
            if (cmd.scan && in_reg.command == tgr_pkg::CMD_TICK && valid_reg[idx_reg])
            begin
                if (rel_reg[idx_reg] && since > {16'b0, cfg.release_delay_ms})
                begin
                    valid_reg[idx_reg] <= 1'b0;
                    if (!dbl_reg[idx_reg] && pan_reg[idx_reg])
                    begin
                        panning_reg <= 1'b0;
                    end
                end
                else if (tick_push && !pan_reg[idx_reg])
                begin
                    panning_reg <= 1'b1;
                end
                if (tick_push && n_reg < (RW+1)'(tgr_pkg::MAX_RESULTS))
                begin
                    n_reg <= n_reg + 1'b1;
                end
            end
            if (cmd.act && in_reg.command == tgr_pkg::CMD_BEGIN && !dbl_hit
                && !match_found_reg)
            begin
                if (free_found_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                else
                begin
                    n_reg <= n_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_reg <= request;
        end
        if (cmd.load)
        begin
            px_reg          <= tgr_pkg::to_pixels(in_reg.pos_x, cfg.pixel_scale);
            py_reg          <= tgr_pkg::to_pixels(in_reg.pos_y, cfg.pixel_scale);
            qx_reg          <= tgr_pkg::to_pixels(in_reg.prev_x, cfg.pixel_scale);
            qy_reg          <= tgr_pkg::to_pixels(in_reg.prev_y, cfg.pixel_scale);
            rsq_reg         <= {13'b0, cfg.double_tap_radius} * {13'b0, cfg.double_tap_radius};
            idx_reg         <= '0;
            best_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_idx_reg    <= '0;
            match_idx_reg   <= '0;
            free_idx_reg    <= '0;
            bestd_reg       <= '0;
        end
        if (cmd.scan)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (in_reg.command == tgr_pkg::CMD_TICK)
            begin
                if (valid_reg[idx_reg] && !(rel_reg[idx_reg]
                    && since > {16'b0, cfg.release_delay_ms}) && tick_push)
                begin
                    pan_reg[idx_reg] <= 1'b1;
                end
                if (tick_push && n_reg < (RW+1)'(tgr_pkg::MAX_RESULTS))
                begin
                    buf_reg[n_reg[RW-1:0]] <= '{tick_kind, ident_reg[idx_reg],
                        ex_reg[idx_reg], ey_reg[idx_reg], travel_reg[idx_reg]};
                end
            end
            else
            begin
                if (valid_reg[idx_reg])
                begin
                    if (!best_found_reg || scan_d < bestd_reg)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= idx_reg;
                        bestd_reg      <= scan_d;
                    end
                    if (!match_found_reg && ident_reg[idx_reg] == in_reg.touch_id)
                    begin
                        match_found_reg <= 1'b1;
                        match_idx_reg   <= idx_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
            end
        end
        if (cmd.act)
        begin
            root_reg <= '0;
            bit_reg  <= 30'h1000_0000;
            unique case (in_reg.command)
                tgr_pkg::CMD_BEGIN:
                begin
                    if (dbl_hit)
                    begin
                        dbl_reg[best_idx_reg] <= 1'b1;
                    end
                    else if (match_found_reg)
                    begin
                        ex_reg[match_idx_reg] <= px_reg;
                        ey_reg[match_idx_reg] <= py_reg;
                    end
                    else if (free_found_reg)
                    begin
                        ident_reg[free_idx_reg]  <= in_reg.touch_id;
                        ex_reg[free_idx_reg]     <= px_reg;
                        ey_reg[free_idx_reg]     <= py_reg;
                        birth_reg[free_idx_reg]  <= now_reg;
                        rtime_reg[free_idx_reg]  <= '0;
                        rel_reg[free_idx_reg]    <= 1'b0;
                        travel_reg[free_idx_reg] <= '0;
                        pan_reg[free_idx_reg]    <= 1'b0;
                        dbl_reg[free_idx_reg]    <= 1'b0;
                    end
                    else
                    begin
                        buf_reg[n_reg[RW-1:0]] <= '{tgr_pkg::KIND_FULL, in_reg.touch_id,
                            px_reg, py_reg, 16'd0};
                    end
                end
                tgr_pkg::CMD_MOVE:
                begin
                    rem_reg <= {1'b0, move_d};
                    if (match_found_reg)
                    begin
                        ex_reg[match_idx_reg] <= px_reg;
                        ey_reg[match_idx_reg] <= py_reg;
                    end
                end
                tgr_pkg::CMD_END:
                begin
                    if (match_found_reg)
                    begin
                        rel_reg[match_idx_reg]   <= 1'b1;
                        rtime_reg[match_idx_reg] <= now_reg;
                    end
                end
                tgr_pkg::CMD_TICK:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.sqrt_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.move_write)
        begin
            travel_reg[match_idx_reg] <= tsum[16] ? tgr_pkg::TRAVEL_MAX : tsum[15:0];
        end
        if (cmd.emit)
        begin
            out_reg <= '{buf_reg[k_reg].kind, buf_reg[k_reg].id, buf_reg[k_reg].x,
                         buf_reg[k_reg].y, buf_reg[k_reg].tr, panning_reg,
                         ({1'b0, k_reg} == n_reg - 1'b1)};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= (RW+1)'(tgr_pkg::MAX_RESULTS))
        else $error("result count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (n_reg != '0) && ({1'b0, k_reg} < n_reg))
        else $error("emit beyond buffered results");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_step |-> $onehot(bit_reg))
        else $error("root bit lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result after last");

endmodule

[sv/touch_gesture_recognizer.sv]
// Top level of the touch gesture recogniser.
// Sequence: each request is loaded, scanned against every contact table entry and acted on;
// a move with a matching contact then runs 15 root steps and a travel write; buffered results
// are then emitted one per cycle, each shown in the cycle after its emit step.
// Requests are handled one at a time: start is taken only while idle, and the table is scanned in turn.
// Reset clears the table valid bits, the clock, the panning flag and loads register defaults.
// Results are strobed for one cycle; the receiver cannot stall.
module touch_gesture_recognizer
#(
    parameter int MAX_TOUCHES = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tgr_pkg::in_t    request,
    output logic            result_valid,
    output tgr_pkg::out_t   result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    tgr_pkg::cfg_t      cfg;
    tgr_pkg::ctrl_cmd_t cmd;
    tgr_pkg::ctrl_sts_t sts;

    tgr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    tgr_dp #(.N(MAX_TOUCHES)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[sim/tgr_checker.sv]
// Checker for the touch gesture recogniser: predicts gesture events and compares results.
`timescale 1ns / 100ps
module tgr_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  tgr_pkg::in_t  request,
    input  logic          result_valid,
    input  tgr_pkg::out_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          pready,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            pending,
    output int            errors
);

    localparam int SLOTS = 8;

    tgr_pkg::cfg_t cfg;
    logic          slot_used [SLOTS];
    logic [15:0]   slot_id [SLOTS];
    logic [13:0]   slot_x [SLOTS];
    logic [13:0]   slot_y [SLOTS];
    logic [31:0]   slot_birth [SLOTS];
    logic [31:0]   slot_rel_at [SLOTS];
    logic          slot_rel [SLOTS];
    logic [15:0]   slot_travel [SLOTS];
    logic          slot_pan [SLOTS];
    logic          slot_dbl [SLOTS];
    logic          pan_active;
    logic [31:0]   clock_ms;
    tgr_pkg::out_t expected_events [$];

    assign pending = expected_events.size();

    function automatic logic [13:0] scale_pt(input logic [11:0] p, input logic [2:0] s);
        logic [31:0] v;
        v = 32'(p) * 32'(s);
        return (v > 32'd16383) ? 14'h3FFF : v[13:0];
    endfunction

    function automatic logic [31:0] sq_distance(input logic [13:0] ax, input logic [13:0] ay,
                                                input logic [13:0] bx, input logic [13:0] by);
        logic [31:0] dx;
        logic [31:0] dy;
        dx = (ax > bx) ? 32'(ax - bx) : 32'(bx - ax);
        dy = (ay > by) ? 32'(ay - by) : 32'(by - ay);
        return dx * dx + dy * dy;
    endfunction

    function automatic logic [31:0] int_root(input logic [31:0] v_in);
        logic [31:0] v;
        logic [31:0] res;
        logic [31:0] b;
        v = v_in;
        res = 0;
        b = 32'h4000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int find_slot(input logic [15:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_id[i] == id)
                return i;
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        errors++;
    endtask

    task automatic predict_gestures(input tgr_pkg::in_t r);
        tgr_pkg::out_t ev [tgr_pkg::MAX_RESULTS];
        int            n;
        int            best;
        int            e;
        logic [31:0]   bestd;
        logic [31:0]   d;
        logic [31:0]   dur;
        logic [31:0]   t;
        logic [13:0]   px;
        logic [13:0]   py;
        logic [13:0]   qx;
        logic [13:0]   qy;
        logic [2:0]    k;
        logic          hit;
        n = 0;
        px = scale_pt(r.pos_x, cfg.pixel_scale);
        py = scale_pt(r.pos_y, cfg.pixel_scale);
        case (r.command)
            tgr_pkg::CMD_BEGIN:
            begin
                best = -1;
                bestd = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i])
                    begin
                        d = sq_distance(slot_x[i], slot_y[i], px, py);
                        if (best < 0 || d < bestd)
                        begin
                            best = i;
                            bestd = d;
                        end
                    end
                end
                if (best >= 0 && bestd < 32'(cfg.double_tap_radius) * 32'(cfg.double_tap_radius)
                    && slot_rel[best] && !slot_pan[best]
                    && (clock_ms - slot_rel_at[best]) < 32'(cfg.double_tap_window_ms))
                    slot_dbl[best] = 1'b1;
                else
                begin
                    e = find_slot(r.touch_id);
                    if (e >= 0)
                    begin
                        slot_x[e] = px;
                        slot_y[e] = py;
                    end
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (!slot_used[i] && e < 0)
                                e = i;
                        if (e < 0)
                        begin
                            ev[n] = '{tgr_pkg::KIND_FULL, r.touch_id, px, py, 16'd0,
                                      1'b0, 1'b0};
                            n++;
                        end
                        else
                        begin
                            slot_used[e] = 1'b1;
                            slot_id[e] = r.touch_id;
                            slot_x[e] = px;
                            slot_y[e] = py;
                            slot_birth[e] = clock_ms;
                            slot_rel_at[e] = 0;
                            slot_rel[e] = 1'b0;
                            slot_travel[e] = 0;
                            slot_pan[e] = 1'b0;
                            slot_dbl[e] = 1'b0;
                        end
                    end
                end
            end
            tgr_pkg::CMD_MOVE:
            begin
                e = find_slot(r.touch_id);
                if (e >= 0)
                begin
                    qx = scale_pt(r.prev_x, cfg.pixel_scale);
                    qy = scale_pt(r.prev_y, cfg.pixel_scale);
                    t = 32'(slot_travel[e]) + int_root(sq_distance(px, py, qx, qy));
                    slot_x[e] = px;
                    slot_y[e] = py;
                    slot_travel[e] = (t > 32'hFFFF) ? tgr_pkg::TRAVEL_MAX : t[15:0];
                end
            end
            tgr_pkg::CMD_END:
            begin
                e = find_slot(r.touch_id);
                if (e >= 0)
                begin
                    slot_rel[e] = 1'b1;
                    slot_rel_at[e] = clock_ms;
                end
            end
            default:
            begin
                clock_ms = clock_ms + 1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i])
                    begin
                        dur = clock_ms - slot_birth[i];
                        hit = 1'b0;
                        k = tgr_pkg::KIND_TAP;
                        if (slot_rel[i]
                            && (clock_ms - slot_rel_at[i]) > 32'(cfg.release_delay_ms))
                        begin
                            if (slot_dbl[i])
                            begin
                                k = tgr_pkg::KIND_DOUBLE;
                                hit = 1'b1;
                            end
                            else if (slot_pan[i])
                            begin
                                pan_active = 1'b0;
                                k = tgr_pkg::KIND_PAN_ENDED;
                                hit = 1'b1;
                            end
                            else if (dur > 32'(cfg.tap_min_ms) && dur < 32'(cfg.tap_max_ms))
                            begin
                                k = tgr_pkg::KIND_TAP;
                                hit = 1'b1;
                            end
                            slot_used[i] = 1'b0;
                        end
                        else if (dur > 32'(cfg.pan_min_ms) && slot_travel[i] > cfg.pan_min_travel)
                        begin
                            hit = 1'b1;
                            if (!slot_pan[i])
                            begin
                                slot_pan[i] = 1'b1;
                                pan_active = 1'b1;
                                k = tgr_pkg::KIND_PAN_BEGAN;
                            end
                            else
                                k = tgr_pkg::KIND_PAN;
                        end
                        if (hit && n < tgr_pkg::MAX_RESULTS)
                        begin
                            ev[n] = '{k, slot_id[i], slot_x[i], slot_y[i], slot_travel[i],
                                      1'b0, 1'b0};
                            n++;
                        end
                    end
                end
            end
        endcase
        for (int j = 0; j < n; j++)
        begin
            ev[j].panning_now = pan_active;
            ev[j].last = (j == n - 1);
            expected_events.push_back(ev[j]);
        end
    endtask

    task automatic compare_event(input tgr_pkg::out_t got);
        tgr_pkg::out_t want;
        if (expected_events.size() == 0)
        begin
            report_mismatch("unexpected result kind", 0, got.kind);
        end
        else
        begin
            want = expected_events.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", want.kind, got.kind);
            if (got.out_id !== want.out_id)
                report_mismatch("out_id", want.out_id, got.out_id);
            if (got.out_x !== want.out_x)
                report_mismatch("out_x", want.out_x, got.out_x);
            if (got.out_y !== want.out_y)
                report_mismatch("out_y", want.out_y, got.out_y);
            if (got.out_travel !== want.out_travel)
                report_mismatch("out_travel", want.out_travel, got.out_travel);
            if (got.panning_now !== want.panning_now)
                report_mismatch("panning_now", want.panning_now, got.panning_now);
            if (got.last !== want.last)
                report_mismatch("last", want.last, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg = '{3'd1, 16'd250, 16'd150, 16'd500, 16'd250, 16'd10, 13'd30, 16'd300};
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            pan_active = 1'b0;
            clock_ms = 0;
            expected_events.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    tgr_pkg::REG_PIXEL_SCALE:   cfg.pixel_scale = pwdata[2:0];
                    tgr_pkg::REG_RELEASE_DELAY: cfg.release_delay_ms = pwdata[15:0];
                    tgr_pkg::REG_TAP_MIN:       cfg.tap_min_ms = pwdata[15:0];
                    tgr_pkg::REG_TAP_MAX:       cfg.tap_max_ms = pwdata[15:0];
                    tgr_pkg::REG_PAN_MIN:       cfg.pan_min_ms = pwdata[15:0];
                    tgr_pkg::REG_PAN_TRAVEL:    cfg.pan_min_travel = pwdata[15:0];
                    tgr_pkg::REG_DT_RADIUS:     cfg.double_tap_radius = pwdata[12:0];
                    default:                    cfg.double_tap_window_ms = pwdata[15:0];
                endcase
            end
            if (result_valid)
                compare_event(result);
            if (start && !busy)
                predict_gestures(request);
        end
    end

endmodule

[sim/touch_gesture_recognizer_tb.sv]
// Testbench top for the touch gesture recogniser: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module touch_gesture_recognizer_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 60;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    tgr_pkg::in_t  request;
    logic          result_valid;
    tgr_pkg::out_t result;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    int            pending;
    int            errors;
    int            cycles;
    int            idle_pct;

    touch_gesture_recognizer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tgr_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .pending(pending), .errors(errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("touch_gesture_recognizer_tb NOT OK");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [15:0] id,
                                input logic [11:0] x, input logic [11:0] y,
                                input logic [11:0] qx, input logic [11:0] qy);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 6);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        request <= '{cmd, id, x, y, qx, qy};
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    task automatic settle;
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] sc, input logic [31:0] rd,
                             input logic [31:0] tmin, input logic [31:0] tmax,
                             input logic [31:0] pmin, input logic [31:0] ptr,
                             input logic [31:0] rad, input logic [31:0] win);
        write_reg(tgr_pkg::REG_PIXEL_SCALE, sc);
        write_reg(tgr_pkg::REG_RELEASE_DELAY, rd);
        write_reg(tgr_pkg::REG_TAP_MIN, tmin);
        write_reg(tgr_pkg::REG_TAP_MAX, tmax);
        write_reg(tgr_pkg::REG_PAN_MIN, pmin);
        write_reg(tgr_pkg::REG_PAN_TRAVEL, ptr);
        write_reg(tgr_pkg::REG_DT_RADIUS, rad);
        write_reg(tgr_pkg::REG_DT_WINDOW, win);
    endtask

    function automatic logic [11:0] pick_pos();
        if ($urandom_range(3) == 0)
            return 12'($urandom);
        return 12'($urandom_range(0, 63));
    endfunction

    task automatic random_touches(input int count);
        logic [15:0] id;
        logic [1:0]  cmd;
        int          roll;
        for (int i = 0; i < count; i++)
        begin
            id = (($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)));
            roll = $urandom_range(99);
            if (roll < 20)
                cmd = tgr_pkg::CMD_BEGIN;
            else if (roll < 50)
                cmd = tgr_pkg::CMD_MOVE;
            else if (roll < 65)
                cmd = tgr_pkg::CMD_END;
            else
                cmd = tgr_pkg::CMD_TICK;
            send_request(cmd, id, pick_pos(), pick_pos(), pick_pos(), pick_pos());
        end
    endtask

    initial
    begin
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: full-range move step, unknown ids
        send_request(tgr_pkg::CMD_BEGIN, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_MOVE, 16'd0, 12'hFFF, 12'hFFF, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_MOVE, 16'hAAAA, 12'd5, 12'd5, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_END, 16'h5555, 12'd0, 12'd0, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_TICK, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        settle();

        write_all(32'd7, 32'd3, 32'd0, 32'hFFFF, 32'd1, 32'd0, 32'h1FFF, 32'hFFFF);
        send_request(tgr_pkg::CMD_BEGIN, 16'hFFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_BEGIN, 16'hFFFF, 12'd0, 12'd0, 12'd0, 12'd0);
        for (int i = 1; i <= 6; i++)
            send_request(tgr_pkg::CMD_BEGIN, 16'(i), 12'(i * 500), 12'(4000 - i * 500),
                         12'd0, 12'd0);
        send_request(tgr_pkg::CMD_BEGIN, 16'h1234, 12'd77, 12'd900, 12'd0, 12'd0);
        for (int i = 0; i < 3; i++)
            send_request(tgr_pkg::CMD_MOVE, 16'd1, 12'hFFF, 12'hFFF, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_END, 16'd2, 12'd0, 12'd0, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_END, 16'd2, 12'd0, 12'd0, 12'd0, 12'd0);
        send_request(tgr_pkg::CMD_MOVE, 16'd2, 12'd1000, 12'd3000, 12'd1001, 12'd2999);
        send_request(tgr_pkg::CMD_BEGIN, 16'h0055, 12'd1000, 12'd3000, 12'd0, 12'd0);
        for (int i = 0; i < 6; i++)
            send_request(tgr_pkg::CMD_TICK, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        settle();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 55;
                2: idle_pct = 31;
                3: idle_pct = 55;
                default: idle_pct = 0;
            endcase
            if (phase == 0)
                write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
            else if (phase == 1)
                write_all(32'd4, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                          32'h1FFF, 32'hFFFF);
            else
                write_all($urandom_range(0, 7), $urandom_range(0, 6), $urandom_range(0, 3),
                          $urandom_range(3, 14), $urandom_range(0, 5),
                          $urandom_range(0, 100), $urandom_range(0, 200),
                          $urandom_range(0, 20));
            random_touches(45);
            settle();
        end

        if (errors == 0)
            $display("touch_gesture_recognizer_tb OK");
        else
            $display("touch_gesture_recognizer_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
sv/tgr_pkg.sv
sv/tgr_cfg.sv
sv/tgr_ctrl.sv
sv/tgr_dp.sv
sv/touch_gesture_recognizer.sv
sim/tgr_checker.sv
sim/touch_gesture_recognizer_tb.sv
